/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the filter project.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define FOIIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, outside reset.
`define FOIIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define FOIIR_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/foiir_pkg.sv */
// Package of the fourth-order IIR filter: widths, defaults and the result type.
// No dependencies; used by the interfaces, the datapath and the top level.
package foiir_pkg;

  localparam int ORDER_DEF      = 4;
  localparam int COEF_FRAC_BITS = 27;
  localparam int HIST_FRAC      = 8;
  localparam int SAMPLE_W       = 16;
  localparam int HIST_W         = 24;
  localparam int COEF_W         = 32;
  localparam int ACC_W          = 64;
  // Wide enough for the register map of any order up to eight.
  localparam int CFG_IDX_W      = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
    logic signed [HIST_W-1:0]   hist_y;
  } foiir_res_t;

endpackage

/* hw/rtl/foiir_cfg_if.sv */
// Configuration write channel of the filter: register index and write data.
// Depends on foiir_pkg for the field widths.
interface foiir_cfg_if import foiir_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/foiir_in_if.sv */
// Sample request channel of the filter: one signed sample and a clear flag.
// Depends on foiir_pkg for the field widths.
interface foiir_in_if import foiir_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       clear;

  modport source (output valid, output sample, output clear, input ready);
  modport sink (input valid, input sample, input clear, output ready);
endinterface

/* hw/rtl/foiir_out_if.sv */
// Result channel of the filter: rounded output sample and saturation flag.
// Depends on foiir_pkg for the field widths.
interface foiir_out_if import foiir_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink (input valid, input filtered, input saturated, output ready);
endinterface

/* hw/rtl/fourth_order_iir_filter.sv */
// Direct-form-I IIR filter with folded symmetric numerator, Q5.27 coefficients.
// An accepted request is registered at the input, its result at the output.
// One request per cycle unless the output stalls; the multiply-accumulate
// and output history update are combinational after the input register.
// Synchronous reset clears the coefficients, both histories and all valid flags.
// Depends on foiir_pkg, the channel interfaces and foiir_datapath.
module fourth_order_iir_filter import foiir_pkg::*; #(
  parameter int ORDER = ORDER_DEF
) (
  input logic         clk,
  input logic         rst_n,
  foiir_cfg_if.sink   cfg_chan,
  foiir_in_if.sink    in_chan,
  foiir_out_if.source out_chan
);

  localparam int NUM_FF = ORDER / 2 + 1;

  logic signed [COEF_W-1:0]   ff_coef_r [0:NUM_FF-1];
  logic signed [COEF_W-1:0]   fb_coef_r [1:ORDER];
  logic signed [SAMPLE_W-1:0] x_hist_r  [1:ORDER];
  logic signed [HIST_W-1:0]   y_hist_r  [1:ORDER];
  logic signed [SAMPLE_W-1:0] x_all     [0:ORDER];

  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_clear_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_filtered_r;
  logic                       out_saturated_r;

  logic       s2_ready;
  logic       s1_fire;
  foiir_res_t res;

  assign cfg_chan.ready     = 1'b1;
  assign s2_ready           = !out_valid_r || out_chan.ready;
  assign s1_fire            = s1_valid_r && s2_ready;
  assign in_chan.ready      = !s1_valid_r || s2_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.filtered  = out_filtered_r;
  assign out_chan.saturated = out_saturated_r;

  always_comb begin
    x_all[0] = s1_sample_r;
    for (int k = 1; k <= ORDER; k++) begin
      x_all[k] = x_hist_r[k];
    end
  end

  foiir_datapath #(
    .ORDER (ORDER)
  ) u_datapath (
    .x_hist  (x_all),
    .y_hist  (y_hist_r),
    .ff_coef (ff_coef_r),
    .fb_coef (fb_coef_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_FF; k++) begin
        ff_coef_r[k] <= '0;
      end
      for (int k = 1; k <= ORDER; k++) begin
        fb_coef_r[k] <= '0;
      end
    end else if (cfg_chan.valid) begin
      for (int k = 0; k < NUM_FF; k++) begin
        if (cfg_chan.index == CFG_IDX_W'(k)) begin
          ff_coef_r[k] <= $signed(cfg_chan.data);
        end
      end
      for (int k = 1; k <= ORDER; k++) begin
        if (cfg_chan.index == CFG_IDX_W'(NUM_FF + k - 1)) begin
          fb_coef_r[k] <= $signed(cfg_chan.data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_sample_r <= in_chan.sample;
      s1_clear_r  <= in_chan.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ORDER; k++) begin
        x_hist_r[k] <= '0;
        y_hist_r[k] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_clear_r) begin
        for (int k = 1; k <= ORDER; k++) begin
          x_hist_r[k] <= '0;
          y_hist_r[k] <= '0;
        end
      end else begin
        for (int k = 2; k <= ORDER; k++) begin
          x_hist_r[k] <= x_hist_r[k-1];
          y_hist_r[k] <= y_hist_r[k-1];
        end
        x_hist_r[1] <= s1_sample_r;
        y_hist_r[1] <= res.hist_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      if (s1_clear_r) begin
        out_filtered_r  <= '0;
        out_saturated_r <= 1'b0;
      end else begin
        out_filtered_r  <= res.filtered;
        out_saturated_r <= res.saturated;
      end
    end
  end

endmodule

/* hw/rtl/foiir_datapath.sv */
// Multiply-accumulate, rounding and saturation of one filter step.
// Depends on foiir_pkg; instantiated by the filter top level.
module foiir_datapath import foiir_pkg::*; #(
  parameter int ORDER = ORDER_DEF
) (
  input  logic signed [SAMPLE_W-1:0] x_hist [0:ORDER],
  input  logic signed [HIST_W-1:0]   y_hist [1:ORDER],
  input  logic signed [COEF_W-1:0]   ff_coef [0:ORDER/2],
  input  logic signed [COEF_W-1:0]   fb_coef [1:ORDER],
  output foiir_res_t                 res
);

  localparam int NUM_FF    = ORDER / 2 + 1;
  localparam int OUT_SHIFT = COEF_FRAC_BITS + HIST_FRAC;
  localparam logic signed [ACC_W-1:0] ONE      = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] HALF_OUT = ONE <<< (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] HALF_HST = ONE <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX  = (ONE <<< (SAMPLE_W - 1)) - ONE;
  localparam logic signed [ACC_W-1:0] OUT_MIN  = ~OUT_MAX;
  localparam logic signed [ACC_W-1:0] HST_MAX  = (ONE <<< (HIST_W - 1)) - ONE;
  localparam logic signed [ACC_W-1:0] HST_MIN  = ~HST_MAX;

  logic signed [SAMPLE_W:0]          x_pair  [NUM_FF];
  logic signed [COEF_W+SAMPLE_W:0]   ff_prod [NUM_FF];
  logic signed [COEF_W+HIST_W-1:0]   fb_prod [1:ORDER];
  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           y_out;
  logic signed [ACC_W-1:0]           y_hst;

  // The numerator is symmetric, so paired taps are added before the multiply.
  always_comb begin
    for (int k = 0; k < NUM_FF; k++) begin
      if (ORDER - k != k) begin
        x_pair[k] = (SAMPLE_W+1)'(x_hist[k]) + (SAMPLE_W+1)'(x_hist[ORDER-k]);
      end else begin
        x_pair[k] = (SAMPLE_W+1)'(x_hist[k]);
      end
      ff_prod[k] = ff_coef[k] * x_pair[k];
    end
    for (int k = 1; k <= ORDER; k++) begin
      fb_prod[k] = fb_coef[k] * y_hist[k];
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_FF; k++) begin
      acc = acc + (ACC_W'(ff_prod[k]) <<< HIST_FRAC);
    end
    for (int k = 1; k <= ORDER; k++) begin
      acc = acc + ACC_W'(fb_prod[k]);
    end
    y_out = (acc + HALF_OUT) >>> OUT_SHIFT;
    y_hst = (acc + HALF_HST) >>> COEF_FRAC_BITS;
  end

  always_comb begin
    if (y_out > OUT_MAX) begin
      res.filtered  = OUT_MAX[SAMPLE_W-1:0];
      res.saturated = 1'b1;
    end else if (y_out < OUT_MIN) begin
      res.filtered  = OUT_MIN[SAMPLE_W-1:0];
      res.saturated = 1'b1;
    end else begin
      res.filtered  = y_out[SAMPLE_W-1:0];
      res.saturated = 1'b0;
    end
    if (y_hst > HST_MAX) begin
      res.hist_y = HST_MAX[HIST_W-1:0];
    end else if (y_hst < HST_MIN) begin
      res.hist_y = HST_MIN[HIST_W-1:0];
    end else begin
      res.hist_y = y_hst[HIST_W-1:0];
    end
  end

endmodule

/* hw/rtl/foiir_checker.sv */
// Port-level checks of the filter's result channel, bound to the top level.
// Depends on assert_macros.svh and foiir_pkg.
`include "assert_macros.svh"

module foiir_checker import foiir_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_filtered,
  input logic                       out_saturated
);

  `FOIIR_ASSERT_NXT_ALWAYS(a_no_result_after_reset, clk, !rst_n, !out_valid)
  `FOIIR_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)
  `FOIIR_ASSERT_NXT(a_payload_held, clk, rst_n, out_valid && !out_ready, $stable(out_filtered) && $stable(out_saturated))
  `FOIIR_ASSERT_IMP(a_sat_at_limit, clk, rst_n, out_valid && out_saturated, out_filtered == 16'sh7fff || out_filtered == 16'sh8000)

endmodule

bind fourth_order_iir_filter foiir_checker u_foiir_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_filtered  (out_chan.filtered),
  .out_saturated (out_chan.saturated)
);

/* dv/fourth_order_iir_filter_test.sv */
// Self-checking testbench of fourth_order_iir_filter: directed table, then random phases.
// Every accepted sample is run through a fixed-point filter predictor and compared in order.
// Depends on foiir_pkg, the three channel interfaces and the filter top level.
module fourth_order_iir_filter_test import foiir_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FF          = ORDER_DEF / 2 + 1;
  localparam int NUM_REG         = NUM_FF + ORDER_DEF;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int END_CYCLES      = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FF0, REG_FF1, REG_FF2, REG_FB1, REG_FB2, REG_FB3, REG_FB4
  } coef_reg_t;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hf;

  typedef enum logic {ROW_CFG, ROW_DATA} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    coef;
    logic                 clr;
    logic [SAMPLE_W-1:0]  smp;
    logic                 typed;
    logic [SAMPLE_W-1:0]  exp_y;
    logic                 exp_sat;
  } dir_row_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } filt_res_t;

  typedef struct packed {
    logic      typed;
    filt_res_t res;
  } req_note_t;

  logic clk;
  logic rst_n;

  foiir_cfg_if cfg_chan ();
  foiir_in_if  in_chan ();
  foiir_out_if out_chan ();

  fourth_order_iir_filter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic signed [COEF_W-1:0]   ff_coef [0:NUM_FF-1];
  logic signed [COEF_W-1:0]   fb_coef [1:ORDER_DEF];
  logic signed [SAMPLE_W-1:0] x_hist [1:ORDER_DEF];
  logic signed [HIST_W-1:0]   y_hist [1:ORDER_DEF];

  filt_res_t expected_q [$];
  req_note_t note_q [$];

  int  err_cnt;
  int  cycle_cnt;
  bit  tx_no_idle;
  bit  rx_no_idle;
  bit  rx_hold_start;

  dir_row_t dir_tbl [$] = '{
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h7fff, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h8000, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b1, 16'h1234, 1'b1, 16'h0000, 1'b0},
    '{ROW_CFG,  REG_FF0, 32'h0800_0000, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b1, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h7fff, 1'b1, 16'h7fff, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h8000, 1'b1, 16'h8000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h0001, 1'b1, 16'h0001, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h0000, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h0000, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FF0, 32'h7fff_ffff, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FF1, 32'h8000_0000, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FF2, 32'h0000_0001, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_UNMAPPED, 32'hffff_ffff, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b1, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h7fff, 1'b1, 16'h7fff, 1'b1},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h8000, 1'b1, 16'h8000, 1'b1},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h7fff, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h8000, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FB1, 32'h7fff_ffff, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FB2, 32'h8000_0000, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FB3, 32'h7fff_ffff, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG,  REG_FB4, 32'h8000_0000, 1'b0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h7fff, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h8000, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h7fff, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h0000, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h1234, 1'b0, 16'h0, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b1, 16'h5555, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_DATA, REG_FF0, 32'h0, 1'b0, 16'h8000, 1'b0, 16'h0, 1'b0}
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic filt_res_t filter_step(input logic clr,
                                            input logic signed [SAMPLE_W-1:0] smp);
    filt_res_t r;
    longint    acc;
    longint    y_out;
    longint    y_his;
    longint    tap_sum [0:NUM_FF-1];
    r = '0;
    if (clr) begin
      for (int k = 1; k <= ORDER_DEF; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      return r;
    end
    tap_sum[0] = longint'(smp) + longint'(x_hist[4]);
    tap_sum[1] = longint'(x_hist[1]) + longint'(x_hist[3]);
    tap_sum[2] = longint'(x_hist[2]);
    acc = 0;
    for (int k = 0; k < NUM_FF; k++)
      acc += longint'(ff_coef[k]) * tap_sum[k] * (longint'(1) <<< HIST_FRAC);
    for (int k = 1; k <= ORDER_DEF; k++)
      acc += longint'(fb_coef[k]) * longint'(y_hist[k]);
    y_out = (acc + (longint'(1) <<< (COEF_FRAC_BITS + HIST_FRAC - 1)))
            >>> (COEF_FRAC_BITS + HIST_FRAC);
    y_his = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (y_out > 32767) begin
      y_out = 32767;
      r.saturated = 1'b1;
    end else if (y_out < -32768) begin
      y_out = -32768;
      r.saturated = 1'b1;
    end
    if (y_his > 8388607) y_his = 8388607;
    else if (y_his < -8388608) y_his = -8388608;
    for (int k = ORDER_DEF; k > 1; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[1] = smp;
    y_hist[1] = y_his[HIST_W-1:0];
    r.filtered = y_out[SAMPLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    filt_res_t got;
    filt_res_t want;
    req_note_t note;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got.filtered  = out_chan.filtered;
        got.saturated = out_chan.saturated;
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: filtered %0d saturated %0b",
                     got.filtered, got.saturated);
        end else begin
          want = expected_q.pop_front();
          if (got.filtered !== want.filtered || got.saturated !== want.saturated) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: filtered exp %0d got %0d, saturated exp %0b got %0b",
                       want.filtered, got.filtered, want.saturated, got.saturated);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        note = note_q.pop_front();
        want = filter_step(in_chan.clear, in_chan.sample);
        expected_q.push_back(note.typed ? note.res : want);
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index < NUM_FF)
          ff_coef[cfg_chan.index] = cfg_chan.data;
        else if (cfg_chan.index < NUM_REG)
          fb_coef[cfg_chan.index - NUM_FF + 1] = cfg_chan.data;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("fourth_order_iir_filter test failed");
      $finish;
    end
  end

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_start) begin
        out_chan.ready = 1'b0;
        for (int hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++)
          @(negedge clk);
        rx_hold_start = 1'b0;
      end
      out_chan.ready = rx_no_idle || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic send_item(input logic clr, input logic [SAMPLE_W-1:0] smp,
                           input req_note_t note);
    @(negedge clk);
    while (!tx_no_idle && $urandom_range(0, 99) < 24) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    note_q.push_back(note);
    in_chan.valid  = 1'b1;
    in_chan.sample = smp;
    in_chan.clear  = clr;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.index = idx;
    cfg_chan.data  = value;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  initial begin
    req_note_t         note;
    logic [COEF_W-1:0] value;
    logic [SAMPLE_W-1:0] smp;
    logic              clr;
    int                pick;
    bit                wild;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    in_chan.clear  = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data  = '0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    rx_hold_start  = 1'b0;
    err_cnt        = 0;
    cycle_cnt      = 0;
    for (int k = 0; k < NUM_FF; k++) ff_coef[k] = '0;
    for (int k = 1; k <= ORDER_DEF; k++) begin
      fb_coef[k] = '0;
      x_hist[k]  = '0;
      y_hist[k]  = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        drain();
        cfg_write(dir_tbl[i].idx, dir_tbl[i].coef);
      end else begin
        note.typed         = dir_tbl[i].typed;
        note.res.filtered  = dir_tbl[i].exp_y;
        note.res.saturated = dir_tbl[i].exp_sat;
        send_item(dir_tbl[i].clr, dir_tbl[i].smp, note);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      wild = (phase >= 2) && ($urandom_range(0, 3) == 0);
      for (int r = 0; r < NUM_REG; r++) begin
        if (phase == 0) value = 32'h7fff_ffff;
        else if (phase == 1) value = 32'h8000_0000;
        else if (wild) value = $urandom;
        else if (r < NUM_FF) value = $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000;
        else value = $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
        cfg_write(r[CFG_IDX_W-1:0], value);
      end
      cfg_write(CFG_IDX_W'($urandom_range(NUM_REG, 2**CFG_IDX_W - 1)), $urandom);
      if (phase == 4) begin
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 2 && n == 50) begin
          tx_no_idle    = 1'b1;
          rx_hold_start = 1'b1;
        end
        if (phase == 2 && n == 120) tx_no_idle = 1'b0;
        if (phase == 3 && n == 100) drain();
        pick = $urandom_range(0, 99);
        clr  = (n == 0) || (pick < 3);
        if (pick < 10) smp = pick[0] ? 16'h7fff : 16'h8000;
        else if (pick < 40) smp = SAMPLE_W'($urandom_range(0, 511) - 256);
        else smp = SAMPLE_W'($urandom);
        note = '0;
        send_item(clr, smp, note);
      end
      tx_no_idle = 1'b0;
      rx_no_idle = 1'b0;
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("fourth_order_iir_filter test passed");
    end else begin
      $display("fourth_order_iir_filter test failed");
    end
    $finish;
  end

endmodule
